@@ hdl/ffa_pkg.sv @@
`default_nettype none
package ffa_pkg;
    localparam int TableEntriesDefault = 256;
    localparam logic [31:0] PAGE_ADD = 32'h0000_0fff;
    localparam logic [31:0] PAGE_MASK = 32'hffff_f000;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_LOST = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DECIDE,
        S_NEXT_RD,
        S_NEXT_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } ffa_state_t;

    typedef struct packed {
        logic done;
    } ffa_ctl_t;
endpackage
`default_nettype wire

@@ hdl/ffa_ram.sv @@
`default_nettype none
module ffa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ hdl/first_fit_free_list_allocator_core.sv @@
// Channel | Direction | Signals
// command | in        | start, op, region_addr, region_size, page_round (busy: out)
// result  | out       | done, alloc_addr, status, free_bytes, entries_used,
//         |           | peak_entries, lost_count, lost_bytes
// Each request walks the table RAM (one write port, one read port) once to
// find the entry and, where needed, once more to shift later entries up or down.
// Reset clears the count and counters only; the table needs no clearing pass.
// done pulses for one cycle, no stall.
`default_nettype none
module first_fit_free_list_allocator_core
    import ffa_pkg::*;
#(
    parameter int TABLE_ENTRIES = TableEntriesDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        op,
    input  wire logic [31:0] region_addr,
    input  wire logic [31:0] region_size,
    input  wire logic        page_round,
    output logic             done,
    output logic [31:0]      alloc_addr,
    output logic [1:0]       status,
    output logic [31:0]      free_bytes,
    output logic [8:0]       entries_used,
    output logic [8:0]       peak_entries,
    output logic [31:0]      lost_count,
    output logic [31:0]      lost_bytes
);
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

    ffa_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next, peak_reg, peak_next;
    logic [CW-1:0] k_reg, k_next, n_reg, n_next;
    logic          op_reg, op_next;
    logic [31:0]   addr_reg, addr_next, size_reg, size_next;
    logic [31:0]   prev_s_reg, prev_s_next, prev_l_reg, prev_l_next;
    logic [31:0]   cur_s_reg, cur_s_next, cur_l_reg, cur_l_next;
    logic [31:0]   total_reg, total_next, lc_reg, lc_next, lb_reg, lb_next;
    logic [31:0]   out_addr_reg, out_addr_next;
    logic [1:0]    st_reg, st_next;
    logic          up_reg, up_next;
    logic [31:0]   carry_s_reg, carry_s_next, carry_l_reg, carry_l_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0]   wdata, rdata;
    logic [31:0]   rs, rl, sz_in;
    logic [31:0]   sum_a, sum_b, sum_y;
    ffa_ctl_t      ctl;

    assign rs = rdata[63:32];
    assign rl = rdata[31:0];
    assign sz_in = page_round ? ((region_size + PAGE_ADD) & PAGE_MASK) : region_size;
    assign sum_y = sum_a + sum_b;

    ffa_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            peak_reg <= '0;
            total_reg <= '0;
            lc_reg <= '0;
            lb_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            peak_reg <= peak_next;
            total_reg <= total_next;
            lc_reg <= lc_next;
            lb_reg <= lb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        n_reg <= n_next;
        op_reg <= op_next;
        addr_reg <= addr_next;
        size_reg <= size_next;
        prev_s_reg <= prev_s_next;
        prev_l_reg <= prev_l_next;
        cur_s_reg <= cur_s_next;
        cur_l_reg <= cur_l_next;
        out_addr_reg <= out_addr_next;
        st_reg <= st_next;
        up_reg <= up_next;
        carry_s_reg <= carry_s_next;
        carry_l_reg <= carry_l_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (count_reg == '0) ? S_DECIDE : S_SCAN_RD;
                end
            end
            S_SCAN_RD:  state_next = S_SCAN_CHK;
            S_SCAN_CHK:
            begin
                if ((op_reg == OP_ALLOC && rl >= size_reg) || (op_reg == OP_FREE && rs > addr_reg)
                    || k_reg + 1'b1 == count_reg)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_DECIDE:   state_next = ctl.done ? S_DONE : S_SHIFT_RD;
            S_NEXT_RD:  state_next = S_NEXT_CHK;
            S_NEXT_CHK: state_next = S_SHIFT_RD;
            S_SHIFT_RD: state_next = S_SHIFT_WR;
            S_SHIFT_WR: state_next = (n_reg == k_reg) ? S_DONE : S_SHIFT_RD;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        peak_next = peak_reg;
        total_next = total_reg;
        lc_next = lc_reg;
        lb_next = lb_reg;
        k_next = k_reg;
        n_next = n_reg;
        op_next = op_reg;
        addr_next = addr_reg;
        size_next = size_reg;
        prev_s_next = prev_s_reg;
        prev_l_next = prev_l_reg;
        cur_s_next = cur_s_reg;
        cur_l_next = cur_l_reg;
        out_addr_next = out_addr_reg;
        st_next = st_reg;
        up_next = up_reg;
        carry_s_next = carry_s_reg;
        carry_l_next = carry_l_reg;
        we = 1'b0;
        waddr = k_reg[AW-1:0];
        wdata = {cur_s_reg, cur_l_reg};
        raddr = k_reg[AW-1:0];
        sum_a = '0;
        sum_b = '0;
        ctl = '{done: 1'b0};
        unique case (state_reg)
            S_IDLE:
            begin
                op_next = op;
                addr_next = region_addr;
                size_next = sz_in;
                k_next = '0;
                out_addr_next = '0;
                st_next = ST_OK;
                up_next = 1'b0;
                raddr = '0;
            end
            S_SCAN_RD:  raddr = k_reg[AW-1:0];
            S_SCAN_CHK:
            begin
                cur_s_next = rs;
                cur_l_next = rl;
                if (op_reg == OP_ALLOC)
                begin
                    if (rl < size_reg)
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
                else if (!(rs > addr_reg))
                begin
                    prev_s_next = rs;
                    prev_l_next = rl;
                    k_next = k_reg + 1'b1;
                end
            end
            S_DECIDE:
            begin
                n_next = k_reg;
                if (op_reg == OP_ALLOC)
                begin
                    if (k_reg == count_reg)
                    begin
                        st_next = ST_NOFIT;
                        ctl.done = 1'b1;
                    end
                    else
                    begin
                        out_addr_next = cur_s_reg;
                        total_next = total_reg - size_reg;
                        we = 1'b1;
                        wdata = {cur_s_reg + size_reg, cur_l_reg - size_reg};
                        if (cur_l_reg == size_reg)
                        begin
                            count_next = count_reg - 1'b1;
                            n_next = count_reg - 1'b1;
                            up_next = 1'b0;
                            ctl.done = (k_reg == count_reg - 1'b1);
                        end
                        else
                        begin
                            ctl.done = 1'b1;
                        end
                    end
                end
                else
                begin
                    sum_a = prev_s_reg;
                    sum_b = prev_l_reg;
                    if (k_reg != '0 && sum_y == addr_reg)
                    begin
                        total_next = total_reg + size_reg;
                        we = 1'b1;
                        waddr = AW'(k_reg - 1'b1);
                        if (k_reg < count_reg && addr_reg + size_reg == cur_s_reg)
                        begin
                            wdata = {prev_s_reg, prev_l_reg + size_reg + cur_l_reg};
                            count_next = count_reg - 1'b1;
                            n_next = count_reg - 1'b1;
                            ctl.done = (k_reg == count_reg - 1'b1);
                        end
                        else
                        begin
                            wdata = {prev_s_reg, prev_l_reg + size_reg};
                            ctl.done = 1'b1;
                        end
                    end
                    else if (k_reg < count_reg && addr_reg + size_reg == cur_s_reg)
                    begin
                        total_next = total_reg + size_reg;
                        we = 1'b1;
                        wdata = {addr_reg, cur_l_reg + size_reg};
                        ctl.done = 1'b1;
                    end
                    else if (count_reg < FULL)
                    begin
                        total_next = total_reg + size_reg;
                        count_next = count_reg + 1'b1;
                        if (count_reg + 1'b1 > peak_reg)
                        begin
                            peak_next = count_reg + 1'b1;
                        end
                        up_next = 1'b1;
                        n_next = count_reg;
                        carry_s_next = addr_reg;
                        carry_l_next = size_reg;
                        if (k_reg == count_reg)
                        begin
                            we = 1'b1;
                            wdata = {addr_reg, size_reg};
                            ctl.done = 1'b1;
                        end
                    end
                    else
                    begin
                        st_next = ST_LOST;
                        lc_next = lc_reg + 1'b1;
                        lb_next = lb_reg + size_reg;
                        ctl.done = 1'b1;
                    end
                end
                if (!ctl.done && !up_next)
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_NEXT_RD:  raddr = k_reg[AW-1:0];
            S_NEXT_CHK: raddr = k_reg[AW-1:0];
            S_SHIFT_RD:
            begin
                if (up_reg)
                begin
                    raddr = AW'(n_reg - 1'b1);
                end
                else
                begin
                    raddr = k_reg[AW-1:0];
                end
            end
            S_SHIFT_WR:
            begin
                we = 1'b1;
                if (up_reg)
                begin
                    waddr = n_reg[AW-1:0];
                    if (n_reg == k_reg)
                    begin
                        wdata = {carry_s_reg, carry_l_reg};
                    end
                    else
                    begin
                        wdata = rdata;
                        n_next = n_reg - 1'b1;
                    end
                end
                else
                begin
                    waddr = AW'(k_reg - 1'b1);
                    wdata = rdata;
                    if (k_reg != n_reg)
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            S_DONE:     raddr = '0;
            default:    raddr = '0;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    assign alloc_addr = out_addr_reg;
    assign status = st_reg;
    assign free_bytes = total_reg;
    assign entries_used = 9'(count_reg);
    assign peak_entries = 9'(peak_reg);
    assign lost_count = lc_reg;
    assign lost_bytes = lb_reg;
endmodule
`default_nettype wire

@@ hdl/ffa_checker.sv @@
`default_nettype none
module ffa_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic [1:0] status,
    input wire logic [8:0] entries_used,
    input wire logic [8:0] peak_entries,
    input wire logic [31:0] alloc_addr
);
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done outside busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("transfer not taken");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status != 2'd3)) else $error("bad status");
    a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != 2'd0) |-> alloc_addr == 32'd0) else $error("addr on fail");
    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> peak_entries >= entries_used) else $error("peak below count");
endmodule

bind first_fit_free_list_allocator_core ffa_checker u_ffa_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .entries_used(entries_used), .peak_entries(peak_entries),
    .alloc_addr(alloc_addr)
);
`default_nettype wire
